FILE: rtl/mi_pkg.sv
// modular inverse package: widths, status codes and sequencer states
// used by the channel interfaces and the modular_inverse top level
`timescale 1ns / 1ps

package mi_pkg;

    localparam int WIDTH = 32;
    // cofactor of the modulus needs sign plus headroom for two subtractions
    localparam int COEF_W = WIDTH + 3;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_NO_INV  = 2'd1,
        STATUS_INVALID = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_SPECIAL
    } state_t;

endpackage

FILE: rtl/mi_req_if.sv
// request channel of the modular inverse: value and modulus with valid/ready
// depends on mi_pkg
`timescale 1ns / 1ps

interface mi_req_if;
    logic                     valid;
    logic                     ready;
    logic [mi_pkg::WIDTH-1:0] value;
    logic [mi_pkg::WIDTH-1:0] modulus;

    modport source (output valid, output value, output modulus, input ready);
    modport sink   (input valid, input value, input modulus, output ready);
endinterface

FILE: rtl/mi_rsp_if.sv
// response channel of the modular inverse: inverse and status with valid/ready
// depends on mi_pkg
`timescale 1ns / 1ps

interface mi_rsp_if;
    logic                     valid;
    logic                     ready;
    logic [mi_pkg::WIDTH-1:0] inverse;
    mi_pkg::status_t          status;

    modport source (output valid, output inverse, output status, input ready);
    modport sink   (input valid, input inverse, input status, output ready);
endinterface

FILE: rtl/modular_inverse.sv
// a zero operand, modulus one or two even operands pass through the special state to a
// response; other requests go to the run state, one binary gcd step per cycle:
// a halving or a subtraction in the shared unit
// throughput: one request at a time, the next accepted once the result is registered
// reset clears the sequencer and the response valid; operands need no clearing
// depends on mi_pkg, mi_req_if, mi_rsp_if
`timescale 1ns / 1ps

module modular_inverse (
    input  logic clk,
    input  logic rst_n,
    mi_req_if.sink   req,
    mi_rsp_if.source rsp
);

    localparam int W  = mi_pkg::WIDTH;
    localparam int CW = mi_pkg::COEF_W;

    mi_pkg::state_t  state_reg, state_next;

    // invariants: ua*value + ub*modulus == u, va*value + vb*modulus == v
    logic [W-1:0]           u_reg, u_next;
    logic [W-1:0]           v_reg, v_next;
    logic [W-1:0]           ua_reg, ua_next;
    logic [W-1:0]           va_reg, va_next;
    logic signed [CW-1:0]   ub_reg, ub_next;
    logic signed [CW-1:0]   vb_reg, vb_next;
    logic [W-1:0]           a_reg, a_next;
    logic [W-1:0]           m_reg, m_next;
    mi_pkg::status_t        spec_reg, spec_next;

    logic                   out_valid_reg, out_valid_next;
    logic [W-1:0]           out_inverse_reg, out_inverse_next;
    mi_pkg::status_t        out_status_reg, out_status_next;

    // shared step unit
    logic                   do_sub;
    logic                   ge;
    logic                   side_u;
    logic [W-1:0]           op_x, op_y, op_p, op_q;
    logic signed [CW-1:0]   op_bp, op_bq, a_ext;
    logic                   adj;
    logic [W:0]             coef_sum;
    logic                   wrap;
    logic [W-1:0]           coef_new;
    logic signed [CW-1:0]   cof_sum, cof_new;
    logic [W-1:0]           x_new;
    logic                   slot_free;
    logic                   accept;

    assign accept    = req.valid && req.ready;
    assign slot_free = !out_valid_reg || rsp.ready;

    assign req.ready   = (state_reg == mi_pkg::ST_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.inverse = out_inverse_reg;
    assign rsp.status  = out_status_reg;

    always_comb
    begin
        do_sub = u_reg[0] & v_reg[0];
        ge     = (u_reg >= v_reg);
        // subtract into the larger side, else halve whichever is even (u first)
        side_u = do_sub ? ge : ~u_reg[0];
        op_x   = side_u ? u_reg  : v_reg;
        op_y   = side_u ? v_reg  : u_reg;
        op_p   = side_u ? ua_reg : va_reg;
        op_q   = side_u ? va_reg : ua_reg;
        op_bp  = side_u ? ub_reg : vb_reg;
        op_bq  = side_u ? vb_reg : ub_reg;
        a_ext  = $signed({{(CW - W){1'b0}}, a_reg});
        // odd coefficient pair: move by (modulus, -value) to make both even
        adj    = op_p[0] | op_bp[0];

        if (do_sub)
        begin
            coef_sum = {1'b0, op_p} - {1'b0, op_q};
        end
        else
        begin
            coef_sum = {1'b0, op_p} + (adj ? {1'b0, m_reg} : {(W + 1){1'b0}});
        end
        wrap = do_sub & coef_sum[W];

        if (do_sub)
        begin
            coef_new = wrap ? (coef_sum[W-1:0] + m_reg) : coef_sum[W-1:0];
            cof_sum  = op_bp - op_bq - (wrap ? a_ext : {CW{1'b0}});
            cof_new  = cof_sum;
            x_new    = op_x - op_y;
        end
        else
        begin
            coef_new = coef_sum[W:1];
            cof_sum  = op_bp - (adj ? a_ext : {CW{1'b0}});
            cof_new  = cof_sum >>> 1;
            x_new    = op_x >> 1;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        u_next           = u_reg;
        v_next           = v_reg;
        ua_next          = ua_reg;
        va_next          = va_reg;
        ub_next          = ub_reg;
        vb_next          = vb_reg;
        a_next           = a_reg;
        m_next           = m_reg;
        spec_next        = spec_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_inverse_next = out_inverse_reg;
        out_status_next  = out_status_reg;

        case (state_reg)
            mi_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    a_next  = req.value;
                    m_next  = req.modulus;
                    u_next  = req.value;
                    v_next  = req.modulus;
                    ua_next = {{(W - 1){1'b0}}, 1'b1};
                    ub_next = {CW{1'b0}};
                    va_next = {W{1'b0}};
                    vb_next = {{(CW - 1){1'b0}}, 1'b1};
                    if (req.value == '0 || req.modulus == '0)
                    begin
                        spec_next  = mi_pkg::STATUS_INVALID;
                        state_next = mi_pkg::ST_SPECIAL;
                    end
                    else if (req.modulus == {{(W - 1){1'b0}}, 1'b1})
                    begin
                        spec_next  = mi_pkg::STATUS_OK;
                        state_next = mi_pkg::ST_SPECIAL;
                    end
                    else if (!req.value[0] && !req.modulus[0])
                    begin
                        spec_next  = mi_pkg::STATUS_NO_INV;
                        state_next = mi_pkg::ST_SPECIAL;
                    end
                    else
                    begin
                        state_next = mi_pkg::ST_RUN;
                    end
                end
            end

            mi_pkg::ST_RUN:
            begin
                if (u_reg == '0)
                begin
                    // v holds the gcd, va the inverse when the gcd is one
                    if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        if (v_reg == {{(W - 1){1'b0}}, 1'b1})
                        begin
                            out_inverse_next = va_reg;
                            out_status_next  = mi_pkg::STATUS_OK;
                        end
                        else
                        begin
                            out_inverse_next = {W{1'b0}};
                            out_status_next  = mi_pkg::STATUS_NO_INV;
                        end
                        state_next = mi_pkg::ST_IDLE;
                    end
                end
                else if (side_u)
                begin
                    u_next  = x_new;
                    ua_next = coef_new;
                    ub_next = cof_new;
                end
                else
                begin
                    v_next  = x_new;
                    va_next = coef_new;
                    vb_next = cof_new;
                end
            end

            mi_pkg::ST_SPECIAL:
            begin
                if (slot_free)
                begin
                    out_valid_next   = 1'b1;
                    out_inverse_next = {W{1'b0}};
                    out_status_next  = spec_reg;
                    state_next       = mi_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = mi_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mi_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg           <= u_next;
        v_reg           <= v_next;
        ua_reg          <= ua_next;
        va_reg          <= va_next;
        ub_reg          <= ub_next;
        vb_reg          <= vb_next;
        a_reg           <= a_next;
        m_reg           <= m_next;
        spec_reg        <= spec_next;
        out_inverse_reg <= out_inverse_next;
        out_status_reg  <= out_status_next;
    end

`ifndef NO_ASSERTIONS
    a_v_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mi_pkg::ST_RUN |-> v_reg != '0)
        else $error("gcd operand v reached zero while running");

    a_one_odd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mi_pkg::ST_RUN |-> (u_reg[0] || v_reg[0]))
        else $error("both gcd operands even while running");

    a_coef_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mi_pkg::ST_RUN |-> (ua_reg < m_reg && va_reg < m_reg))
        else $error("coefficient left the range below the modulus");

    a_finish_on_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mi_pkg::ST_RUN && state_next != mi_pkg::ST_RUN) |-> u_reg == '0)
        else $error("run ended before u reached zero");

    a_busy_until_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != mi_pkg::ST_IDLE && state_next == mi_pkg::ST_IDLE) |=> out_valid_reg)
        else $error("request finished without a registered response");
`endif

endmodule
